/* hw/rtl/vgti_pkg.sv */
// Shared types and constants for the voxel grid trilinear interpolator.
// No dependencies.
package vgti_pkg;

    localparam int GRID_X_DEF = 32;
    localparam int GRID_Y_DEF = 32;
    localparam int GRID_Z_DEF = 32;
    localparam int COORD_W    = 5;
    localparam int VAL_W      = 16;
    localparam int POS_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int QDEPTH     = 4;
    localparam int PADDR_W    = 5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [VAL_W-1:0] ONE_Q88 = 16'sd256;

    typedef enum logic [PADDR_W-1:0] {
        REG_ORIGIN_X   = 5'd0,
        REG_ORIGIN_Y   = 5'd4,
        REG_ORIGIN_Z   = 5'd8,
        REG_INV_STEP_X = 5'd12,
        REG_INV_STEP_Y = 5'd16,
        REG_INV_STEP_Z = 5'd20
    } reg_addr_t;

    typedef struct packed {
        logic                   cmd;
        logic [COORD_W-1:0]     voxel_x;
        logic [COORD_W-1:0]     voxel_y;
        logic [COORD_W-1:0]     voxel_z;
        logic signed [VAL_W-1:0] voxel_value;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] interp_value;
        logic                    outside;
    } rsp_t;

    // Classified item between front and back. Cell indices fit 8 bits (grid <= 256).
    typedef struct packed {
        logic                    is_write;
        logic                    outside;
        logic [7:0]              cx;
        logic [7:0]              cy;
        logic [7:0]              cz;
        logic [FRAC_W-1:0]       fx;
        logic [FRAC_W-1:0]       fy;
        logic [FRAC_W-1:0]       fz;
        logic signed [VAL_W-1:0] wval;
    } work_t;

endpackage

/* hw/rtl/vgti_stream_if.sv */
// Valid/ready channel carrying one payload type.
// No dependencies.
interface vgti_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/voxel_grid_trilinear_interp_top.sv */
// Voxel grid trilinear interpolator, top level.
// Pipeline: 3 front stages, 1 queue slot and 5 back stages counting the output register;
// one request per cycle sustained while the receiver takes answers, set by the eight
// parity-banked grid RAMs read in parallel and the pipelined weights. Writes produce
// no result; queries produce one. Reset clears control state and config registers
// (origin 0, inv_step 1.0); grid contents are undefined until written.
// Depends on vgti_pkg, vgti_stream_if, vgti_front, vgti_fifo, vgti_back.
module voxel_grid_trilinear_interp_top
    import vgti_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    vgti_stream_if.sink        req,
    vgti_stream_if.source      rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic signed [POS_W-1:0] origin_reg [3];
    logic [POS_W-1:0]        inv_step_reg [3];
    logic  f_valid, f_ready, b_valid, b_ready;
    work_t f_data, b_data;
    logic  cfg_we;

    // Config: zero-wait APB, written at the access phase.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                origin_reg[a]   <= '0;
                inv_step_reg[a] <= 32'h0001_0000;
            end
        end
        else if (cfg_we)
        begin
            unique case (paddr)
                REG_ORIGIN_X:   origin_reg[0]   <= pwdata;
                REG_ORIGIN_Y:   origin_reg[1]   <= pwdata;
                REG_ORIGIN_Z:   origin_reg[2]   <= pwdata;
                REG_INV_STEP_X: inv_step_reg[0] <= pwdata;
                REG_INV_STEP_Y: inv_step_reg[1] <= pwdata;
                REG_INV_STEP_Z: inv_step_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_ORIGIN_X:   prdata = origin_reg[0];
            REG_ORIGIN_Y:   prdata = origin_reg[1];
            REG_ORIGIN_Z:   prdata = origin_reg[2];
            REG_INV_STEP_X: prdata = inv_step_reg[0];
            REG_INV_STEP_Y: prdata = inv_step_reg[1];
            REG_INV_STEP_Z: prdata = inv_step_reg[2];
            default:        prdata = '0;
        endcase
    end

    // Front: map positions to cells.
    vgti_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .origin    (origin_reg),
        .inv_step  (inv_step_reg),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (req.data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    // Queue decouples the front from the back.
    vgti_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    // Back: grid storage and blending; writes land here in request order.
    vgti_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_data   (b_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );
endmodule

/* hw/rtl/vgti_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vgti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* hw/rtl/vgti_front.sv */
// Front end: maps a query to cell index and fraction per axis, passes writes.
// Depends on vgti_pkg. Three stages: subtract, multiply, classify.
module vgti_front
    import vgti_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [POS_W-1:0] origin [3],
    input  logic [POS_W-1:0]        inv_step [3],
    input  logic                    in_valid,
    output logic                    in_ready,
    input  req_t                    in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output work_t                   out_data
);
    logic  adv;
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    req_t  s1_req_reg, s2_req_reg;
    logic signed [POS_W:0] s1_diff_reg [3];
    logic [2*POS_W-1:0]    s2_prod_reg [3];
    logic [2:0]            s2_neg_reg;
    logic [2:0]            s2_zero_reg;
    work_t s3_reg, s3_next;
    logic [POS_W-1:0]      ip [3];
    logic [2:0]            ax_out;
    logic [31:0]           lim [3];

    // Whole pipe moves together; holds when the last stage is blocked.
    assign adv      = !s3_valid_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

    assign lim[0] = 32'(GRID_X - 1);
    assign lim[1] = 32'(GRID_Y - 1);
    assign lim[2] = 32'(GRID_Z - 1);

    always_comb
    begin
        s3_next = '0;
        for (int a = 0; a < 3; a++)
        begin
            ip[a]     = s2_prod_reg[a][2*POS_W-1:POS_W];
            ax_out[a] = (s2_neg_reg[a] && !s2_zero_reg[a]) || (ip[a] >= lim[a]);
        end
        s3_next.is_write = (s2_req_reg.cmd == CMD_WRITE);
        s3_next.outside  = |ax_out;
        if (s2_req_reg.cmd == CMD_WRITE)
        begin
            s3_next.cx = 8'(s2_req_reg.voxel_x);
            s3_next.cy = 8'(s2_req_reg.voxel_y);
            s3_next.cz = 8'(s2_req_reg.voxel_z);
            s3_next.outside = (32'(s2_req_reg.voxel_x) >= 32'(GRID_X)) ||
                              (32'(s2_req_reg.voxel_y) >= 32'(GRID_Y)) ||
                              (32'(s2_req_reg.voxel_z) >= 32'(GRID_Z));
        end
        else
        begin
            s3_next.cx = ip[0][7:0];
            s3_next.cy = ip[1][7:0];
            s3_next.cz = ip[2][7:0];
        end
        s3_next.fx   = s2_prod_reg[0][POS_W-1:FRAC_W];
        s3_next.fy   = s2_prod_reg[1][POS_W-1:FRAC_W];
        s3_next.fz   = s2_prod_reg[2][POS_W-1:FRAC_W];
        s3_next.wval = s2_req_reg.voxel_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_req_reg <= in_data;
            s1_diff_reg[0] <= (POS_W+1)'(in_data.pos_x) - (POS_W+1)'(origin[0]);
            s1_diff_reg[1] <= (POS_W+1)'(in_data.pos_y) - (POS_W+1)'(origin[1]);
            s1_diff_reg[2] <= (POS_W+1)'(in_data.pos_z) - (POS_W+1)'(origin[2]);
            s2_req_reg <= s1_req_reg;
            for (int a = 0; a < 3; a++)
            begin
                s2_neg_reg[a]  <= s1_diff_reg[a][POS_W];
                s2_zero_reg[a] <= (inv_step[a] == '0);
                // 32x32 unsigned product; a negative diff is dropped by the flags
                s2_prod_reg[a] <= s1_diff_reg[a][POS_W] ? '0 :
                                  (2*POS_W)'(s1_diff_reg[a][POS_W-1:0]) *
                                  (2*POS_W)'(inv_step[a]);
            end
            s3_reg <= s3_next;
        end
    end
endmodule

/* hw/rtl/vgti_fifo.sv */
// Short queue between front and back.
// Depends on vgti_pkg.
module vgti_fifo
    import vgti_pkg::*;
#(
    parameter int DEPTH = QDEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_data
);
    localparam int AW = $clog2(DEPTH);
    work_t         slot_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= in_data;
        end
    end
endmodule

/* hw/rtl/vgti_back.sv */
// Back end: eight parity banks of the grid, weight products, blend, round.
// Depends on vgti_pkg and vgti_ram.
module vgti_back
    import vgti_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output rsp_t  out_data
);
    localparam int HX = (GRID_X + 1) / 2;
    localparam int HY = (GRID_Y + 1) / 2;
    localparam int HZ = (GRID_Z + 1) / 2;
    localparam int HXW = (HX > 1) ? $clog2(HX) : 1;
    localparam int HYW = (HY > 1) ? $clog2(HY) : 1;
    localparam int HZW = (HZ > 1) ? $clog2(HZ) : 1;
    localparam int BD  = HX * HY * HZ;
    localparam int BAW = $clog2(BD);
    localparam int NST = 4;

    logic  adv, take;
    logic  v_reg [NST];
    logic  o_reg [NST];
    logic  wr;
    logic [7:0] cx1, cy1, cz1;
    logic [BAW-1:0] baddr [8];
    logic [15:0] rdat [8];
    logic [2:0]  wbank;
    logic [BAW-1:0] waddr;
    // stage registers
    logic [FRAC_W:0] wx_reg [2];
    logic [FRAC_W:0] wy_reg [2];
    logic [FRAC_W:0] wz_reg [2];
    logic [2:0]      par_reg;
    logic [2*FRAC_W+1:0] wxy_reg [2][2];
    logic [FRAC_W:0]     wz2_reg [2];
    logic signed [VAL_W-1:0] val2_reg [8];
    logic [3*FRAC_W:0]   w_reg [8];
    logic signed [VAL_W-1:0] val3_reg [8];
    logic signed [3*FRAC_W+VAL_W+1:0] p_reg [8];
    logic signed [3*FRAC_W+VAL_W+4:0] sum;
    logic signed [3*FRAC_W+VAL_W+4:0] rnd;
    logic signed [VAL_W+4:0] q;
    rsp_t  res_reg, res_next;
    logic  rv_reg;

    // Stall the whole datapath only when the output register is full and blocked.
    assign adv       = !rv_reg || out_ready;
    assign in_ready  = adv;
    assign take      = in_valid && adv;
    assign out_valid = rv_reg;
    assign out_data  = res_reg;

    assign wr    = take && in_data.is_write && !in_data.outside;
    assign cx1   = in_data.cx + 8'd1;
    assign cy1   = in_data.cy + 8'd1;
    assign cz1   = in_data.cz + 8'd1;
    assign wbank = {in_data.cx[0], in_data.cy[0], in_data.cz[0]};
    assign waddr = BAW'((32'(in_data.cx[7:1]) * HY + 32'(in_data.cy[7:1])) * HZ +
                        32'(in_data.cz[7:1]));

    // Bank b holds points with parity b; read the corner of the cell with that parity.
    for (genvar b = 0; b < 8; b++)
    begin : g_bank
        logic [7:0] bx, by, bz;
        always_comb
        begin
            bx = (in_data.cx[0] == b[2]) ? in_data.cx : cx1;
            by = (in_data.cy[0] == b[1]) ? in_data.cy : cy1;
            bz = (in_data.cz[0] == b[0]) ? in_data.cz : cz1;
            baddr[b] = BAW'((32'(HXW'(bx[7:1])) * HY + 32'(HYW'(by[7:1]))) * HZ +
                            32'(HZW'(bz[7:1])));
        end
        vgti_ram #(.WIDTH(VAL_W), .DEPTH(BD)) u_ram (
            .clk   (clk),
            .we    (wr && (wbank == 3'(b))),
            .waddr (waddr),
            .wdata (in_data.wval),
            .re    (adv),
            .raddr (baddr[b]),
            .rdata (rdat[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            rv_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid && !in_data.is_write;
            for (int s = 1; s < NST; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            rv_reg <= v_reg[NST-1];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 8; k++)
        begin
            sum = sum + (3*FRAC_W+VAL_W+5)'(p_reg[k]);
        end
        rnd = sum + (3*FRAC_W+VAL_W+5)'(64'sh8000_0000_0000);
        q   = rnd[3*FRAC_W+VAL_W+4:3*FRAC_W];
        res_next.outside = o_reg[NST-1];
        if (o_reg[NST-1])
        begin
            res_next.interp_value = ONE_Q88;
        end
        else if (q > (VAL_W+5)'(32767))
        begin
            res_next.interp_value = 16'sh7FFF;
        end
        else if (q < -(VAL_W+5)'(32768))
        begin
            res_next.interp_value = 16'sh8000;
        end
        else
        begin
            res_next.interp_value = q[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 0: axis weights, parity, RAM read issued
            o_reg[0] <= in_data.outside;
            for (int s = 1; s < NST; s++)
            begin
                o_reg[s] <= o_reg[s-1];
            end
            wx_reg[0] <= 17'h10000 - 17'(in_data.fx);
            wx_reg[1] <= 17'(in_data.fx);
            wy_reg[0] <= 17'h10000 - 17'(in_data.fy);
            wy_reg[1] <= 17'(in_data.fy);
            wz_reg[0] <= 17'h10000 - 17'(in_data.fz);
            wz_reg[1] <= 17'(in_data.fz);
            par_reg <= {in_data.cx[0], in_data.cy[0], in_data.cz[0]};
            // stage 1: x*y weights, route bank data to corners
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    wxy_reg[i][j] <= 34'(wx_reg[i]) * 34'(wy_reg[j]);
                end
            end
            wz2_reg  <= wz_reg;
            for (int k = 0; k < 8; k++)
            begin
                val2_reg[k] <= rdat[3'(k) ^ par_reg];
            end
            // stage 2: full weights
            for (int k = 0; k < 8; k++)
            begin
                w_reg[k] <= 49'(wxy_reg[k>>2][(k>>1)&1]) * 49'(wz2_reg[k&1]);
            end
            val3_reg <= val2_reg;
            // stage 3: sample times weight
            for (int k = 0; k < 8; k++)
            begin
                p_reg[k] <= (3*FRAC_W+VAL_W+2)'(val3_reg[k]) *
                            $signed({1'b0, w_reg[k]});
            end
            // stage 4: sum and round into output register
            res_reg <= res_next;
        end
    end
endmodule

/* dv/tb_voxel_grid_trilinear_interp_top.sv */
// Testbench for the voxel grid trilinear interpolator: drives sample writes and
// queries, predicts each answer from its own grid copy, compares field by field.
// Depends on vgti_pkg, vgti_stream_if and voxel_grid_trilinear_interp_top.
module tb_voxel_grid_trilinear_interp_top
    import vgti_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GX = 32;
    localparam int GY = 32;
    localparam int GZ = 32;
    localparam int WIN = 4;
    localparam int MAX_TRIES = 20;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    vgti_stream_if #(.payload_t(req_t)) req_ch ();
    vgti_stream_if #(.payload_t(rsp_t)) rsp_ch ();

    voxel_grid_trilinear_interp_top dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Predictor state: its own copy of the registers and of the grid.
    logic signed [31:0] grid_origin [3];
    logic [31:0]        grid_inv_step [3];
    logic signed [15:0] sample_mem [GX*GY*GZ];
    bit                 sample_known [GX*GY*GZ];

    rsp_t   pending_answers [$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     hold_long = 1'b0;

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
    end

    // Abort on a hang; one global cycle counter covers every phase.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("voxel_grid_trilinear_interp_top: mismatch");
            $finish;
        end
    end

    task automatic report_error(input string what);
        error_count++;
        $display("ERROR @%0d: %s", cycle_count, what);
    endtask

    function automatic int flat_index(input int x, input int y, input int z);
        return (x * GY + y) * GZ + z;
    endfunction

    // Map one axis onto the grid; returns 0 when the point lies outside.
    function automatic bit locate_axis(input logic signed [31:0] pos, input int ax,
                                       input int size, output int cell_idx,
                                       output logic [15:0] frac);
        logic signed [32:0] diff;
        logic [63:0] prod;
        diff = 33'(signed'(pos)) - 33'(signed'(grid_origin[ax]));
        if (grid_inv_step[ax] == 0)
            prod = '0;
        else
        begin
            if (diff < 0)
                return 1'b0;
            prod = 64'(diff[31:0]) * 64'(grid_inv_step[ax]);
        end
        if (prod[63:32] >= size - 1)
            return 1'b0;
        cell_idx = int'(prod[63:32]);
        frac = prod[31:16];
        return 1'b1;
    endfunction

    // True when a query lands inside and one of its corners was never written.
    function automatic bit touches_unknown(input req_t q);
        int cell_idx [3];
        logic [15:0] frac [3];
        if (!locate_axis(q.pos_x, 0, GX, cell_idx[0], frac[0]) ||
            !locate_axis(q.pos_y, 1, GY, cell_idx[1], frac[1]) ||
            !locate_axis(q.pos_z, 2, GZ, cell_idx[2], frac[2]))
            return 1'b0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 2; k++)
                    if (!sample_known[flat_index(cell_idx[0]+i, cell_idx[1]+j,
                                                 cell_idx[2]+k)])
                        return 1'b1;
        return 1'b0;
    endfunction

    // Blend the eight corners in exact arithmetic, round half up, saturate.
    function automatic rsp_t predict_sample(input req_t q);
        rsp_t r;
        int cell_idx [3];
        logic [15:0] frac [3];
        logic [16:0] wt [3][2];
        logic signed [95:0] acc;
        logic signed [95:0] rounded;
        logic [63:0] w;
        r.outside = 1'b1;
        r.interp_value = ONE_Q88;
        if (!locate_axis(q.pos_x, 0, GX, cell_idx[0], frac[0]) ||
            !locate_axis(q.pos_y, 1, GY, cell_idx[1], frac[1]) ||
            !locate_axis(q.pos_z, 2, GZ, cell_idx[2], frac[2]))
            return r;
        for (int a = 0; a < 3; a++)
        begin
            wt[a][0] = 17'd65536 - frac[a];
            wt[a][1] = {1'b0, frac[a]};
        end
        acc = '0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 2; k++)
                begin
                    w = 64'(wt[0][i]) * 64'(wt[1][j]) * 64'(wt[2][k]);
                    acc += 96'(sample_mem[flat_index(cell_idx[0]+i, cell_idx[1]+j,
                                                     cell_idx[2]+k)])
                           * signed'({32'd0, w});
                end
        rounded = (acc + (96'sd1 <<< 47)) >>> 48;
        r.outside = 1'b0;
        if (rounded > 32767)
            r.interp_value = 16'sh7fff;
        else if (rounded < -32768)
            r.interp_value = 16'sh8000;
        else
            r.interp_value = rounded[15:0];
        return r;
    endfunction

    // Check every accepted answer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_answers.size() == 0)
                report_error("answer with no query outstanding");
            else
            begin
                rsp_t e;
                e = pending_answers.pop_front();
                if (rsp_ch.data.outside !== e.outside)
                    report_error($sformatf("outside %0b want %0b",
                                           rsp_ch.data.outside, e.outside));
                if (rsp_ch.data.interp_value !== e.interp_value)
                    report_error($sformatf("interp_value %0d want %0d",
                                           rsp_ch.data.interp_value, e.interp_value));
            end
        end
    end

    // Receiver: random stall per answer, plus one long hold-off on request.
    initial
    begin
        int gap;
        int stall_cycles;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                rsp_ch.ready <= 1'b0;
                stall_cycles = 0;
                while (stall_cycles < 200)
                begin
                    @(posedge clk);
                    stall_cycles++;
                end
                hold_long = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Send one request; update the grid copy or queue the predicted answer.
    task automatic send_request(input req_t item, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (item.cmd == CMD_WRITE)
        begin
            sample_mem[flat_index(item.voxel_x, item.voxel_y, item.voxel_z)] =
                item.voxel_value;
            sample_known[flat_index(item.voxel_x, item.voxel_y, item.voxel_z)] = 1'b1;
        end
        else
            pending_answers.push_back(predict_sample(item));
    endtask

    task automatic go_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register over the configuration port: setup, then access.
    task automatic write_reg(input reg_addr_t addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_ORIGIN_X:   grid_origin[0] = value;
            REG_ORIGIN_Y:   grid_origin[1] = value;
            REG_ORIGIN_Z:   grid_origin[2] = value;
            REG_INV_STEP_X: grid_inv_step[0] = value;
            REG_INV_STEP_Y: grid_inv_step[1] = value;
            REG_INV_STEP_Z: grid_inv_step[2] = value;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] oz, input logic [31:0] sx,
                                input logic [31:0] sy, input logic [31:0] sz);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_INV_STEP_X, sx);
        write_reg(REG_INV_STEP_Y, sy);
        write_reg(REG_INV_STEP_Z, sz);
    endtask

    function automatic req_t make_write(input int x, input int y, input int z,
                                        input logic [15:0] v);
        req_t r;
        r = '0;
        r.cmd = CMD_WRITE;
        r.voxel_x = COORD_W'(x);
        r.voxel_y = COORD_W'(y);
        r.voxel_z = COORD_W'(z);
        r.voxel_value = v;
        r.pos_x = $urandom();
        r.pos_y = $urandom();
        r.pos_z = $urandom();
        return r;
    endfunction

    function automatic req_t make_query(input logic [31:0] px, input logic [31:0] py,
                                        input logic [31:0] pz);
        req_t r;
        r = '0;
        r.cmd = CMD_QUERY;
        r.voxel_x = COORD_W'($urandom());
        r.voxel_y = COORD_W'($urandom());
        r.voxel_z = COORD_W'($urandom());
        r.voxel_value = VAL_W'($urandom());
        r.pos_x = px;
        r.pos_y = py;
        r.pos_z = pz;
        return r;
    endfunction

    // Random sample: one of the two extremes half the time, to reach saturation, else any 16-bit value.
    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 3))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // A position along one axis inside the low corner block (cell 0..WIN-1), given
    // the current origin and step; otherwise a raw random or boundary value.
    function automatic logic [31:0] draw_pos(input int ax);
        logic [63:0] target;
        logic [63:0] off;
        if ($urandom_range(0, 9) < 8 && grid_inv_step[ax] != 0)
        begin
            target = {32'(($urandom_range(0, WIN - 1))), 32'($urandom())};
            off = target / grid_inv_step[ax];
            if (off[63:32] == 0)
                return grid_origin[ax] + off[31:0];
        end
        case ($urandom_range(0, 2))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // A query that reads only written samples; fall back to a write if none is found.
    function automatic req_t draw_safe_query();
        req_t r;
        int tries;
        tries = 0;
        r = make_query(draw_pos(0), draw_pos(1), draw_pos(2));
        while (touches_unknown(r) && tries < MAX_TRIES)
        begin
            r = make_query(draw_pos(0), draw_pos(1), draw_pos(2));
            tries++;
        end
        if (touches_unknown(r))
            r = make_write($urandom_range(0, WIN), $urandom_range(0, WIN),
                           $urandom_range(0, WIN), draw_sample());
        return r;
    endfunction

    // Fill the low corner block and the high corner cell that queries reach.
    task automatic fill_corner_blocks();
        for (int x = 0; x <= WIN; x++)
            for (int y = 0; y <= WIN; y++)
                for (int z = 0; z <= WIN; z++)
                    send_request(make_write(x, y, z, 16'($urandom())), 1'b1);
        for (int x = GX - 2; x < GX; x++)
            for (int y = GY - 2; y < GY; y++)
                for (int z = GZ - 2; z < GZ; z++)
                    send_request(make_write(x, y, z, 16'($urandom())), 1'b1);
    endtask

    // Directed: extremes, edges of the interior, zero step, negative offset, maximum step.
    task automatic test_directed();
        set_geometry(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_request(make_write(0, 0, 0, 16'h7fff));
        send_request(make_write(31, 31, 31, 16'h8000));
        send_request(make_write(1, 1, 1, 16'h0100));
        send_request(make_query(32'h0, 32'h0, 32'h0));
        send_request(make_query(32'h0_8000, 32'h0_8000, 32'h0_8000));
        send_request(make_query(32'h1E_FFFF, 32'h1E_FFFF, 32'h1E_FFFF));
        send_request(make_query(32'h1F_0000, 32'h0, 32'h0));
        send_request(make_query(32'hFFFF_FFFF, 32'h0, 32'h0));
        send_request(make_query(32'h8000_0000, 32'h7fff_ffff, 32'h0));
        send_request(make_query(32'h0, 32'h0, 32'h7fff_ffff));
        go_idle();
        // Zero step: the axis collapses to coordinate 0, negative offset allowed.
        set_geometry(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_request(make_query(32'h8000_0000, 32'h7fff_ffff, 32'hFFFF_FFFF));
        send_request(make_query(32'h0, 32'h0, 32'h0));
        go_idle();
        // Maximum step: tiny offsets land in low cells with a fraction near one.
        set_geometry(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(make_query(32'h0, 32'h0, 32'h0));
        send_request(make_query(32'h1, 32'h0, 32'h0));
        send_request(make_query(32'h0, 32'h0, 32'h3));
        go_idle();
    endtask

    // Random mix of writes and queries under one geometry.
    task automatic test_random_mix(input int count, input int write_pct);
        req_t r;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < write_pct)
                r = make_write($urandom_range(0, 31), $urandom_range(0, 31),
                               $urandom_range(0, 31), draw_sample());
            else
                r = draw_safe_query();
            send_request(r);
        end
    endtask

    // Long receiver hold-off while requests keep arriving back to back.
    task automatic test_backpressure();
        hold_long = 1'b1;
        for (int n = 0; n < 60; n++)
            send_request(draw_safe_query(), 1'b1);
        go_idle();
    endtask

    initial
    begin
        for (int a = 0; a < 3; a++)
        begin
            grid_origin[a] = '0;
            grid_inv_step[a] = 32'h1_0000;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Fill the corners first so that no query ever reads an unwritten sample.
        fill_corner_blocks();
        go_idle();
        test_directed();
        set_geometry(32'h0001_8000, 32'hFFF0_0000, 32'h0, 32'h1_0000, 32'h2_0000,
                     32'h0_8000);
        test_random_mix(410, 30);
        go_idle();
        set_geometry($urandom(), $urandom(), $urandom(), $urandom_range(1, 32'h4_0000),
                     $urandom_range(1, 32'h4_0000), $urandom_range(1, 32'h4_0000));
        test_random_mix(410, 30);
        test_backpressure();
        set_geometry(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1_0000, 32'h0,
                     32'h1_0000);
        test_random_mix(410, 30);
        go_idle();
        if (error_count == 0)
            $display("voxel_grid_trilinear_interp_top: match");
        else
            $display("voxel_grid_trilinear_interp_top: mismatch");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/vgti_pkg.sv
hw/rtl/vgti_stream_if.sv
hw/rtl/vgti_ram.sv
hw/rtl/vgti_front.sv
hw/rtl/vgti_fifo.sv
hw/rtl/vgti_back.sv
hw/rtl/voxel_grid_trilinear_interp_top.sv
dv/tb_voxel_grid_trilinear_interp_top.sv
